/* sv/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

   localparam int DEPTH   = 8;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VAL_W   = 32;
   localparam int PRI_W   = 16;
   localparam int CAP_W   = 4;
   localparam int OCC_W   = 4;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      OUT_EMPTY,
      OUT_FULL
   } out_state_type;

   // controller to datapath
   typedef struct packed {
      logic             load;        // beat accepted, capture result
      logic             enq;         // insert carried entry
      logic             deq;         // pop front entry
      status_type       status;
      logic [CNT_W-1:0] count;       // entries held before the beat
      logic [CNT_W-1:0] count_after; // entries held after the beat
   } cmd_type;

endpackage : spq_pkg
`default_nettype wire

/* sv/spq_if.sv */
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface spq_req_if;
   import spq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [VAL_W-1:0] entry_value;
   logic signed [PRI_W-1:0] entry_priority;

   modport source (output valid, output req_type, output entry_value,
                   output entry_priority, input ready);
   modport sink   (input valid, input req_type, input entry_value,
                   input entry_priority, output ready);
endinterface : spq_req_if

interface spq_rsp_if;
   import spq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [VAL_W-1:0] out_value;
   logic signed [PRI_W-1:0] out_priority;
   logic [OCC_W-1:0]        occupancy;

   modport source (output valid, output status, output out_value,
                   output out_priority, output occupancy, input ready);
   modport sink   (input valid, input status, input out_value,
                   input out_priority, input occupancy, output ready);
endinterface : spq_rsp_if
`default_nettype wire

/* sv/spq_ctrl.sv */
// Controller: entry count, capacity register, handshake and output state.
`default_nettype none
module spq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_type,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic                       csr_wr_en,
   input  wire logic [spq_pkg::CAP_W-1:0]  csr_wr_data,
   output spq_pkg::cmd_type                cmd
);
   import spq_pkg::*;

   out_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] limit;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // capacity saturates at the store depth
   always_comb begin
      if (32'(cap_ff) < DEPTH) begin
         limit = CNT_W'(cap_ff);
      end else begin
         limit = CNT_W'(DEPTH);
      end
   end

   always_comb begin
      state_in  = state_ff;
      rsp_valid = 1'b0;
      req_ready = 1'b1;
      case (state_ff)
         OUT_EMPTY: begin
            req_ready = 1'b1;
         end
         OUT_FULL: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      accept = req_valid && req_ready;
      if (accept) begin
         state_in = OUT_FULL;
      end else if (state_ff == OUT_FULL && rsp_ready) begin
         state_in = OUT_EMPTY;
      end

      cmd.load   = accept;
      cmd.enq    = 1'b0;
      cmd.deq    = 1'b0;
      cmd.status = ST_OK;
      cmd.count  = count_ff;
      count_in   = count_ff;
      if (req_type == REQ_DEQUEUE) begin
         if (count_ff == '0) begin
            cmd.status = ST_UNDERFLOW;
         end else begin
            cmd.deq  = accept;
            count_in = accept ? count_ff - CNT_W'(1) : count_ff;
         end
      end else begin
         if (count_ff >= limit) begin
            cmd.status = ST_OVERFLOW;
         end else begin
            cmd.enq  = accept;
            count_in = accept ? count_ff + CNT_W'(1) : count_ff;
         end
      end
      cmd.count_after = count_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond store depth");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_DEQUEUE && count_ff != '0)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("dequeue did not drop the count");

   a_refuse_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_ENQUEUE && count_ff >= limit)
      |=> count_ff == $past(count_ff))
      else $error("refused enqueue changed the count");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> state_ff == OUT_FULL)
      else $error("request stalled with empty output stage");

endmodule : spq_ctrl
`default_nettype wire

/* sv/spq_dp.sv */
// Datapath: shifting cell row holding the sorted store, plus result register.
`default_nettype none
module spq_dp (
   input  wire logic                              clock,
   input  wire logic signed [spq_pkg::VAL_W-1:0]  entry_value,
   input  wire logic signed [spq_pkg::PRI_W-1:0]  entry_priority,
   input  wire spq_pkg::cmd_type                  cmd,
   output logic [1:0]                             status,
   output logic signed [spq_pkg::VAL_W-1:0]       out_value,
   output logic signed [spq_pkg::PRI_W-1:0]       out_priority,
   output logic [spq_pkg::OCC_W-1:0]              occupancy
);
   import spq_pkg::*;

   logic signed [VAL_W-1:0] val_ff [DEPTH];
   logic signed [PRI_W-1:0] pri_ff [DEPTH];
   logic signed [VAL_W-1:0] val_in [DEPTH];
   logic signed [PRI_W-1:0] pri_in [DEPTH];
   logic signed [VAL_W-1:0] dn_val [DEPTH];
   logic signed [PRI_W-1:0] dn_pri [DEPTH];
   logic signed [VAL_W-1:0] up_val [DEPTH];
   logic signed [PRI_W-1:0] up_pri [DEPTH];
   logic [DEPTH-1:0]        ge;
   logic [DEPTH-1:0]        ge_prev;

   logic [1:0]              status_ff;
   logic signed [VAL_W-1:0] out_value_ff;
   logic signed [PRI_W-1:0] out_priority_ff;
   logic [OCC_W-1:0]        occupancy_ff;

   // each cell: held and at least the new priority
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         ge[k] = (CNT_W'(k) < cmd.count) && (pri_ff[k] >= entry_priority);
      end
      ge_prev[0] = 1'b1;
      dn_val[0]  = '0;
      dn_pri[0]  = '0;
      for (int k = 1; k < DEPTH; k++) begin
         ge_prev[k] = ge[k-1];
         dn_val[k]  = val_ff[k-1];
         dn_pri[k]  = pri_ff[k-1];
      end
      for (int k = 0; k < DEPTH - 1; k++) begin
         up_val[k] = val_ff[k+1];
         up_pri[k] = pri_ff[k+1];
      end
      up_val[DEPTH-1] = val_ff[DEPTH-1];
      up_pri[DEPTH-1] = pri_ff[DEPTH-1];

      for (int k = 0; k < DEPTH; k++) begin
         val_in[k] = val_ff[k];
         pri_in[k] = pri_ff[k];
         if (cmd.enq) begin
            if (!ge[k] && ge_prev[k]) begin
               val_in[k] = entry_value;
               pri_in[k] = entry_priority;
            end else if (!ge[k]) begin
               val_in[k] = dn_val[k];
               pri_in[k] = dn_pri[k];
            end
         end else if (cmd.deq) begin
            val_in[k] = up_val[k];
            pri_in[k] = up_pri[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         val_ff[k] <= val_in[k];
         pri_ff[k] <= pri_in[k];
      end
      if (cmd.load) begin
         status_ff    <= cmd.status;
         occupancy_ff <= OCC_W'(cmd.count_after);
         if (cmd.deq) begin
            out_value_ff    <= val_ff[0];
            out_priority_ff <= pri_ff[0];
         end else begin
            out_value_ff    <= '0;
            out_priority_ff <= '0;
         end
      end
   end

   assign status       = status_ff;
   assign out_value    = out_value_ff;
   assign out_priority = out_priority_ff;
   assign occupancy    = occupancy_ff;

endmodule : spq_dp
`default_nettype wire

/* sv/sorted_priority_queue_top.sv */
// Top level of the bounded sorted priority queue.
// A request beat accepted at a clock edge has its response valid from that edge on.
// One beat per cycle while responses are taken; the cell row compares all slots at once and shifts in one step.
// The output register parts the sides: a new beat is taken while the response is being taken.
// Reset (synchronous, active high): queue empty, capacity 5, no response pending.
// Slot contents are not cleared; only slots below the entry count are ever read.
`default_nettype none
module sorted_priority_queue_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   spq_req_if.sink                         req_bus,
   spq_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_wr_en,
   input  wire logic [spq_pkg::CAP_W-1:0]  csr_wr_data
);
   import spq_pkg::*;

   cmd_type cmd;

   // controller: count, capacity, handshake and response-stage state
   spq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_type    (req_bus.req_type),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd)
   );

   // datapath: sorted cell row and response payload register
   spq_dp u_dp (
      .clock          (clock),
      .entry_value    (req_bus.entry_value),
      .entry_priority (req_bus.entry_priority),
      .cmd            (cmd),
      .status         (rsp_bus.status),
      .out_value      (rsp_bus.out_value),
      .out_priority   (rsp_bus.out_priority),
      .occupancy      (rsp_bus.occupancy)
   );

endmodule : sorted_priority_queue_top
`default_nettype wire
